// ----- rtl/tmw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmw_pkg: shared constants for the text marquee window
// Field widths, input modes, register map and reset values.
// ----------------------------------------------------------------------------
package tmw_pkg;

   localparam int TEXT_DEPTH_DEF = 256;
   localparam int MAX_WINDOW_DEF = 64;

   localparam int CODE_W  = 21;
   localparam int MODE_W  = 2;
   localparam int WIN_W   = 7;
   localparam int TICK_W  = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SHOW   = 2'd3;

   // Register indexes (byte address / 4).
   localparam logic [1:0] REG_WINDOW_WIDTH   = 2'd0;
   localparam logic [1:0] REG_SCROLL_RIGHT   = 2'd1;
   localparam logic [1:0] REG_STEP_INTERVAL  = 2'd2;
   localparam logic [1:0] REG_SEPARATOR_CODE = 2'd3;

   localparam logic [WIN_W-1:0]  WINDOW_WIDTH_RST   = 7'd16;
   localparam logic              SCROLL_RIGHT_RST   = 1'b0;
   localparam logic [TICK_W-1:0] STEP_INTERVAL_RST  = 32'd1;
   localparam logic [CODE_W-1:0] SEPARATOR_CODE_RST = 21'd124;

   localparam logic [CODE_W-1:0] SPACE_CODE = 21'h20;

   // Source of the character in the result stage.
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_TEXT,
      SRC_SEP,
      SRC_SPACE
   } src_type;

endpackage : tmw_pkg
`default_nettype wire

// ----- rtl/tmw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : tmw_ram
`default_nettype wire

// ----- rtl/text_marquee_window_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_marquee_window_core: scrolling window over a stored codepoint text
// Keeps a text of codepoints in a RAM and emits a window of it, one
// character per cycle, scrolling through "text, space, separator, space".
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   ---------------------------------
//  request   start / busy                req_mode, req_char_code
//  response  rsp_valid (one-cycle pulse) rsp_out_code, rsp_present,
//                                        rsp_is_last, rsp_scrolling,
//                                        rsp_overflow
//  control   psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// For clear, append and tick transfers busy stays low and the single
// response appears in the cycle after the transfer. A show of an empty
// text is answered the same way. Any other show transfer holds busy through
// the SETUP state, the RUN state, in which the characters are emitted, and
// the ADVANCE state for the offset update when the text scrolls; its first
// response comes behind SETUP, the first RUN state and the registered read
// of the text RAM, and the rest follow one per cycle from the shared
// position counter.
// Reset is synchronous and clears the text length, offset, tick count and
// registers; the text RAM itself is not cleared, since only entries below the
// text length are ever used. The receiver cannot stall, so responses are
// simply pulsed on rsp_valid.
// ----------------------------------------------------------------------------
module text_marquee_window_core
   import tmw_pkg::*;
#(
   parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [CODE_W-1:0] req_char_code,
   // Response channel
   output logic                   rsp_valid,
   output logic      [CODE_W-1:0] rsp_out_code,
   output logic                   rsp_present,
   output logic                   rsp_is_last,
   output logic                   rsp_scrolling,
   output logic                   rsp_overflow,
   // Control register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   // Positions run over the cyclic sequence of length L = length + 3.
   localparam int ADDR_W = $clog2(TEXT_DEPTH);
   localparam int POS_W  = $clog2(TEXT_DEPTH + 4);
   localparam int CMP_W  = (POS_W > WIN_W) ? POS_W : WIN_W;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SETUP   = 2'd1;
   localparam logic [1:0] ST_RUN     = 2'd2;
   localparam logic [1:0] ST_ADVANCE = 2'd3;

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   logic [WIN_W-1:0]  window_width_ff;
   logic              scroll_right_ff;
   logic [TICK_W-1:0] step_interval_ff;
   logic [CODE_W-1:0] separator_code_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff   <= WINDOW_WIDTH_RST;
         scroll_right_ff   <= SCROLL_RIGHT_RST;
         step_interval_ff  <= STEP_INTERVAL_RST;
         separator_code_ff <= SEPARATOR_CODE_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_WINDOW_WIDTH:   window_width_ff   <= pwdata[WIN_W-1:0];
            REG_SCROLL_RIGHT:   scroll_right_ff   <= pwdata[0];
            REG_STEP_INTERVAL:  step_interval_ff  <= pwdata[TICK_W-1:0];
            REG_SEPARATOR_CODE: separator_code_ff <= pwdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WINDOW_WIDTH:   prdata = CSR_DW'(window_width_ff);
         REG_SCROLL_RIGHT:   prdata = CSR_DW'(scroll_right_ff);
         REG_STEP_INTERVAL:  prdata = CSR_DW'(step_interval_ff);
         REG_SEPARATOR_CODE: prdata = CSR_DW'(separator_code_ff);
         default:            prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer state
   // ------------------------------------------------------------------
   logic [1:0]        state_ff, state_in;
   logic [POS_W-1:0]  text_length_ff, text_length_in;
   logic [POS_W-1:0]  scroll_offset_ff, scroll_offset_in;
   logic [TICK_W-1:0] elapsed_ticks_ff, elapsed_ticks_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WIN_W-1:0]  remaining_ff, remaining_in;
   logic              scrolling_ff, scrolling_in;

   // Response stage
   logic              rsp_valid_ff, rsp_valid_in;
   src_type           rsp_src_ff, rsp_src_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_scroll_ff, rsp_scroll_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // Helpers
   logic              accept;
   logic [WIN_W-1:0]  win_eff;
   logic [POS_W-1:0]  len_cyc;
   logic [POS_W-1:0]  off_norm;
   logic              fits;
   logic [POS_W-1:0]  pos_inc;
   logic              ram_wr_en;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Window width 0 behaves as 1 and anything above MAX_WINDOW is clamped.
   always_comb begin
      if (window_width_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (window_width_ff > WIN_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = window_width_ff;
      end
   end

   assign len_cyc  = text_length_ff + POS_W'(3);
   assign off_norm = (scroll_offset_ff >= len_cyc) ? '0 : scroll_offset_ff;
   assign fits     = CMP_W'(text_length_ff) <= CMP_W'(win_eff);
   // The shared position unit: one increment and wrap compare per cycle.
   assign pos_inc  = ((pos_ff + POS_W'(1)) == len_cyc) ? '0 : (pos_ff + POS_W'(1));

   assign ram_wr_en = accept && (req_mode == MODE_APPEND) &&
                      (text_length_ff < POS_W'(TEXT_DEPTH));

   always_comb begin
      state_in         = state_ff;
      text_length_in   = text_length_ff;
      scroll_offset_in = scroll_offset_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      pos_in           = pos_ff;
      remaining_in     = remaining_ff;
      scrolling_in     = scrolling_ff;
      rsp_valid_in     = 1'b0;
      rsp_src_in       = SRC_NONE;
      rsp_last_in      = 1'b1;
      rsp_scroll_in    = 1'b0;
      rsp_ovf_in       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     text_length_in   = '0;
                     scroll_offset_in = '0;
                     rsp_valid_in     = 1'b1;
                  end
                  MODE_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (ram_wr_en) begin
                        text_length_in = text_length_ff + POS_W'(1);
                     end else begin
                        rsp_ovf_in = 1'b1;
                     end
                  end
                  MODE_TICK: begin
                     rsp_valid_in = 1'b1;
                     if (elapsed_ticks_ff != '1) begin
                        elapsed_ticks_in = elapsed_ticks_ff + TICK_W'(1);
                     end
                  end
                  default: begin
                     // Show: an empty text gives a single empty response.
                     if (text_length_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SETUP;
                     end
                  end
               endcase
            end
         end
         ST_SETUP: begin
            scroll_offset_in = off_norm;
            scrolling_in     = !fits;
            if (fits) begin
               pos_in       = '0;
               remaining_in = WIN_W'(text_length_ff);
            end else begin
               remaining_in = win_eff;
               if (scroll_right_ff && (off_norm != '0)) begin
                  pos_in = len_cyc - off_norm;
               end else if (scroll_right_ff) begin
                  pos_in = '0;
               end else begin
                  pos_in = off_norm;
               end
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rsp_valid_in  = 1'b1;
            rsp_scroll_in = scrolling_ff;
            rsp_last_in   = (remaining_ff == WIN_W'(1));
            if (pos_ff < text_length_ff) begin
               rsp_src_in = SRC_TEXT;
            end else if (pos_ff == (text_length_ff + POS_W'(1))) begin
               rsp_src_in = SRC_SEP;
            end else begin
               rsp_src_in = SRC_SPACE;
            end
            pos_in       = pos_inc;
            remaining_in = remaining_ff - WIN_W'(1);
            if (remaining_ff == WIN_W'(1)) begin
               state_in = scrolling_ff ? ST_ADVANCE : ST_IDLE;
            end
         end
         ST_ADVANCE: begin
            if ((step_interval_ff != '0) && (elapsed_ticks_ff >= step_interval_ff)) begin
               if (scroll_offset_ff >= (text_length_ff + POS_W'(2))) begin
                  scroll_offset_in = '0;
               end else begin
                  scroll_offset_in = scroll_offset_ff + POS_W'(1);
               end
               elapsed_ticks_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         text_length_ff   <= '0;
         scroll_offset_ff <= '0;
         elapsed_ticks_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         text_length_ff   <= text_length_in;
         scroll_offset_ff <= scroll_offset_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      remaining_ff  <= remaining_in;
      scrolling_ff  <= scrolling_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_scroll_ff <= rsp_scroll_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // ------------------------------------------------------------------
   // Text store. The read address is the current position; its data lines
   // up with the response stage in the cycle after.
   // ------------------------------------------------------------------
   logic [CODE_W-1:0] ram_rd_data;

   tmw_ram #(
      .WIDTH (CODE_W),
      .DEPTH (TEXT_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (text_length_ff[ADDR_W-1:0]),
      .wr_data (req_char_code),
      .rd_addr (pos_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Response outputs
   // ------------------------------------------------------------------
   always_comb begin
      case (rsp_src_ff)
         SRC_TEXT:  rsp_out_code = ram_rd_data;
         SRC_SEP:   rsp_out_code = separator_code_ff;
         SRC_SPACE: rsp_out_code = SPACE_CODE;
         default:   rsp_out_code = '0;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_present   = (rsp_src_ff != SRC_NONE);
   assign rsp_is_last   = rsp_last_ff;
   assign rsp_scrolling = rsp_scroll_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule : text_marquee_window_core
`default_nettype wire
